### sv/pose_detection_column_decoder_unit_macros.svh
// Assertion macros shared by the checker of the column decoder.
// Expects clk and rst_n in the scope where a macro is used.
`ifndef POSE_DETECTION_COLUMN_DECODER_UNIT_MACROS_SVH
`define POSE_DETECTION_COLUMN_DECODER_UNIT_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define PDCD_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked out of reset.
`define PDCD_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### sv/pdcd_pkg.sv
// Package of the pose detection column decoder: widths, stream layout,
// shared structs and the truncate/saturate helper. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package pdcd_pkg;

    localparam int DEF_NUM_CLASSES   = 14;
    localparam int DEF_NUM_KEYPOINTS = 4;

    localparam int BOX_CH     = 4;      // centre x, centre y, width, height
    localparam int VAL_W      = 24;     // Q15.8 channel value
    localparam int COORD_W    = 16;
    localparam int CLS_OUT_W  = 4;
    localparam int KN_W       = 2;
    localparam int THR_W      = 9;
    localparam int PAD_W      = 20;
    localparam int RATIO_W    = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 20;
    localparam int DIFF_W     = 27;     // 2*(centre - pad) - size
    localparam int PROD_W     = DIFF_W + RATIO_W + 1;
    localparam int FRAC_SHIFT = 16;     // Q.8 value times Q8.8 ratio
    localparam int COORD_MAX  = 32767;
    localparam int COORD_MIN  = -32768;

    localparam int IN_TDATA_W  = VAL_W;
    localparam int OUT_TDATA_W = 96;

    // output tdata layout, lowest bit first
    localparam int CLS_LSB   = 0;
    localparam int SCORE_LSB = CLS_LSB + CLS_OUT_W;
    localparam int PX_LSB    = SCORE_LSB + VAL_W;
    localparam int PY_LSB    = PX_LSB + COORD_W;
    localparam int BW_LSB    = PY_LSB + COORD_W;
    localparam int BH_LSB    = BW_LSB + COORD_W;
    localparam int KN_LSB    = BH_LSB + COORD_W;
    localparam int USED_W    = KN_LSB + KN_W;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PAD_X     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PAD_Y     = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_RATIO     = 2'd3;

    localparam logic [THR_W-1:0]   THRESHOLD_RST = 9'd128;
    localparam logic [RATIO_W-1:0] RATIO_RST     = 16'd256;

    typedef logic signed [VAL_W-1:0]   value_t;
    typedef logic signed [COORD_W-1:0] coord_t;
    typedef logic [CLS_OUT_W-1:0]      cls_out_t;
    typedef logic [KN_W-1:0]           kn_t;

    // column summary handed from the tracker on the final channel
    typedef struct packed {
        logic     keep;
        cls_out_t cls;
        value_t   score;
    } col_done_t;

    // per-result tags that travel alongside the arithmetic
    typedef struct packed {
        logic     is_box;
        kn_t      kn;
        logic     last;
        cls_out_t cls;
        value_t   score;
    } meta_t;

    typedef struct packed {
        meta_t  meta;
        value_t a_x;
        value_t a_y;
        value_t w;
        value_t h;
    } issue_t;

    typedef struct packed {
        meta_t  meta;
        coord_t px;
        coord_t py;
        coord_t bw;
        coord_t bh;
    } result_t;

    // Truncates a Q.16 (or Q.17 when half is set) product toward zero
    // and saturates to 16 bits signed.
    function automatic coord_t trunc_sat(input logic signed [PROD_W-1:0] p,
                                         input logic half);
        logic signed [PROD_W-1:0] q;
        logic                     frac;
        if (half)
        begin
            q    = p >>> (FRAC_SHIFT + 1);
            frac = |p[FRAC_SHIFT:0];
        end
        else
        begin
            q    = p >>> FRAC_SHIFT;
            frac = |p[FRAC_SHIFT-1:0];
        end
        if (p[PROD_W-1] && frac)
        begin
            q = q + PROD_W'(1);
        end
        if (q > COORD_MAX)
        begin
            return coord_t'(COORD_MAX);
        end
        else if (q < COORD_MIN)
        begin
            return coord_t'(COORD_MIN);
        end
        return coord_t'(q);
    endfunction

endpackage

`default_nettype wire

### sv/pdcd_tracker.sv
// Column tracker: channel counter, strict argmax over class scores and the
// geometry store. Depends on pdcd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module pdcd_tracker #(
    parameter int NUM_CLASSES   = pdcd_pkg::DEF_NUM_CLASSES,
    parameter int NUM_KEYPOINTS = pdcd_pkg::DEF_NUM_KEYPOINTS
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            in_fire,
    input  wire pdcd_pkg::value_t                in_value,
    input  wire logic [pdcd_pkg::THR_W-1:0]      score_threshold,
    output logic                                 at_last,
    output pdcd_pkg::col_done_t                  done,
    output pdcd_pkg::value_t                     col_geom [pdcd_pkg::BOX_CH + 2*NUM_KEYPOINTS]
);

    localparam int GEOM_DEPTH = pdcd_pkg::BOX_CH + 2 * NUM_KEYPOINTS;
    localparam int COLUMN_LEN = pdcd_pkg::BOX_CH + NUM_CLASSES + 2 * NUM_KEYPOINTS;
    localparam int CNT_W      = $clog2(COLUMN_LEN);
    localparam int CLS_W      = (NUM_CLASSES > 1) ? $clog2(NUM_CLASSES) : 1;

    logic [CNT_W-1:0] cnt_reg;
    pdcd_pkg::value_t best_reg;
    pdcd_pkg::value_t best_next;
    logic [CLS_W-1:0] cls_reg;
    logic [CLS_W-1:0] cls_next;
    pdcd_pkg::value_t geom_reg [GEOM_DEPTH];
    logic             is_class;

    always_comb
    begin
        at_last  = (cnt_reg == CNT_W'(COLUMN_LEN - 1));
        is_class = (cnt_reg >= CNT_W'(pdcd_pkg::BOX_CH)) &&
                   (cnt_reg < CNT_W'(pdcd_pkg::BOX_CH + NUM_CLASSES));
        // every column starts the search from score 0, class 0
        if (cnt_reg == '0)
        begin
            best_next = '0;
            cls_next  = '0;
        end
        else
        begin
            best_next = best_reg;
            cls_next  = cls_reg;
        end
        if (is_class && (best_next < in_value))
        begin
            best_next = in_value;
            cls_next  = CLS_W'(cnt_reg - CNT_W'(pdcd_pkg::BOX_CH));
        end
    end

    always_comb
    begin
        done.keep  = in_fire && at_last &&
                     (best_reg >= $signed({1'b0, score_threshold}));
        done.cls   = pdcd_pkg::cls_out_t'(cls_reg);
        done.score = best_reg;
        for (int g = 0; g < GEOM_DEPTH - 1; g++)
        begin
            col_geom[g] = geom_reg[g];
        end
        // final channel is the last keypoint y, still on the input
        col_geom[GEOM_DEPTH-1] = in_value;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            best_reg <= '0;
            cls_reg  <= '0;
        end
        else if (in_fire)
        begin
            cnt_reg  <= at_last ? '0 : cnt_reg + CNT_W'(1);
            best_reg <= best_next;
            cls_reg  <= cls_next;
        end
    end

    // box channels land in entries 0..3, keypoints after the class scores
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            for (int g = 0; g < GEOM_DEPTH; g++)
            begin
                if (cnt_reg == CNT_W'((g < pdcd_pkg::BOX_CH) ? g : g + NUM_CLASSES))
                begin
                    geom_reg[g] <= in_value;
                end
            end
        end
    end

endmodule

`default_nettype wire

### sv/pdcd_emitter.sv
// Result sequencer: snapshots a kept column and issues the box and then
// each keypoint, one per advance. Depends on pdcd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module pdcd_emitter #(
    parameter int NUM_KEYPOINTS = pdcd_pkg::DEF_NUM_KEYPOINTS
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire pdcd_pkg::col_done_t done,
    input  wire pdcd_pkg::value_t    col_geom [pdcd_pkg::BOX_CH + 2*NUM_KEYPOINTS],
    input  wire logic                take,
    output logic                     busy,
    output pdcd_pkg::issue_t         issue
);

    localparam int IDX_W = $clog2(NUM_KEYPOINTS + 1);

    logic                 busy_reg;
    logic [IDX_W-1:0]     idx_reg;
    pdcd_pkg::cls_out_t   cls_reg;
    pdcd_pkg::value_t     score_reg;
    pdcd_pkg::value_t     box_reg [pdcd_pkg::BOX_CH];
    pdcd_pkg::value_t     kpx_reg [NUM_KEYPOINTS];
    pdcd_pkg::value_t     kpy_reg [NUM_KEYPOINTS];
    logic                 is_box;
    logic                 is_last;

    assign busy    = busy_reg;
    assign is_box  = (idx_reg == '0);
    assign is_last = (idx_reg == IDX_W'(NUM_KEYPOINTS));

    always_comb
    begin
        issue.meta.is_box = is_box;
        issue.meta.kn     = is_box ? '0 : pdcd_pkg::kn_t'(idx_reg - IDX_W'(1));
        issue.meta.last   = is_last;
        issue.meta.cls    = cls_reg;
        issue.meta.score  = score_reg;
        issue.a_x         = is_box ? box_reg[0] : kpx_reg[0];
        issue.a_y         = is_box ? box_reg[1] : kpy_reg[0];
        issue.w           = box_reg[2];
        issue.h           = box_reg[3];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            idx_reg  <= '0;
        end
        else if (done.keep)
        begin
            busy_reg <= 1'b1;
            idx_reg  <= '0;
        end
        else if (busy_reg && take)
        begin
            if (is_last)
            begin
                busy_reg <= 1'b0;
            end
            idx_reg <= idx_reg + IDX_W'(1);
        end
    end

    // keypoint pairs shift towards entry 0 as they are issued
    always_ff @(posedge clk)
    begin
        if (done.keep)
        begin
            cls_reg   <= done.cls;
            score_reg <= done.score;
            for (int i = 0; i < pdcd_pkg::BOX_CH; i++)
            begin
                box_reg[i] <= col_geom[i];
            end
            for (int k = 0; k < NUM_KEYPOINTS; k++)
            begin
                kpx_reg[k] <= col_geom[pdcd_pkg::BOX_CH + 2*k];
                kpy_reg[k] <= col_geom[pdcd_pkg::BOX_CH + 2*k + 1];
            end
        end
        else if (busy_reg && take && !is_box)
        begin
            for (int k = 0; k < NUM_KEYPOINTS - 1; k++)
            begin
                kpx_reg[k] <= kpx_reg[k+1];
                kpy_reg[k] <= kpy_reg[k+1];
            end
        end
    end

endmodule

`default_nettype wire

### sv/pdcd_scaler.sv
// Coordinate pipeline: padding removal, multiply by the inverse ratio,
// truncate and saturate, output register. Depends on pdcd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module pdcd_scaler (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire logic                                 issue_valid,
    input  wire pdcd_pkg::issue_t                     issue,
    input  wire logic [pdcd_pkg::PAD_W-1:0]           pad_x,
    input  wire logic [pdcd_pkg::PAD_W-1:0]           pad_y,
    input  wire logic [pdcd_pkg::RATIO_W-1:0]         ratio,
    input  wire logic                                 out_ready,
    output logic                                      take,
    output logic                                      out_valid,
    output pdcd_pkg::result_t                         result
);

    localparam int DW = pdcd_pkg::DIFF_W;
    localparam int PW = pdcd_pkg::PROD_W;

    logic signed [DW-1:0] dx;
    logic signed [DW-1:0] dy;
    logic signed [DW-1:0] ax_next;
    logic signed [DW-1:0] ay_next;
    logic signed [pdcd_pkg::RATIO_W:0] ratio_s;

    logic                 s1_valid_reg;
    pdcd_pkg::meta_t      s1_meta_reg;
    logic signed [DW-1:0] s1_ax_reg;
    logic signed [DW-1:0] s1_ay_reg;
    pdcd_pkg::value_t     s1_w_reg;
    pdcd_pkg::value_t     s1_h_reg;

    logic                 s2_valid_reg;
    pdcd_pkg::meta_t      s2_meta_reg;
    logic signed [PW-1:0] s2_px_reg;
    logic signed [PW-1:0] s2_py_reg;
    logic signed [PW-1:0] s2_pw_reg;
    logic signed [PW-1:0] s2_ph_reg;

    logic                 out_valid_reg;
    pdcd_pkg::result_t    out_reg;

    // the whole pipeline moves together whenever the output can move
    assign take      = !out_valid_reg || out_ready;
    assign out_valid = out_valid_reg;
    assign result    = out_reg;
    assign ratio_s   = $signed({1'b0, ratio});

    always_comb
    begin
        dx = DW'($signed(issue.a_x)) - DW'($signed({1'b0, pad_x}));
        dy = DW'($signed(issue.a_y)) - DW'($signed({1'b0, pad_y}));
        if (issue.meta.is_box)
        begin
            // left/top edge kept exact at Q.9
            ax_next = (dx <<< 1) - DW'($signed(issue.w));
            ay_next = (dy <<< 1) - DW'($signed(issue.h));
        end
        else
        begin
            ax_next = dx;
            ay_next = dy;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (take)
        begin
            s1_valid_reg  <= issue_valid;
            s2_valid_reg  <= s1_valid_reg;
            out_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            s1_meta_reg <= issue.meta;
            s1_ax_reg   <= ax_next;
            s1_ay_reg   <= ay_next;
            s1_w_reg    <= issue.meta.is_box ? issue.w : '0;
            s1_h_reg    <= issue.meta.is_box ? issue.h : '0;

            s2_meta_reg <= s1_meta_reg;
            s2_px_reg   <= PW'(s1_ax_reg) * PW'(ratio_s);
            s2_py_reg   <= PW'(s1_ay_reg) * PW'(ratio_s);
            s2_pw_reg   <= PW'(s1_w_reg) * PW'(ratio_s);
            s2_ph_reg   <= PW'(s1_h_reg) * PW'(ratio_s);

            out_reg.meta <= s2_meta_reg;
            out_reg.px   <= pdcd_pkg::trunc_sat(s2_px_reg, s2_meta_reg.is_box);
            out_reg.py   <= pdcd_pkg::trunc_sat(s2_py_reg, s2_meta_reg.is_box);
            out_reg.bw   <= pdcd_pkg::trunc_sat(s2_pw_reg, 1'b0);
            out_reg.bh   <= pdcd_pkg::trunc_sat(s2_ph_reg, 1'b0);
        end
    end

endmodule

`default_nettype wire

### sv/pose_detection_column_decoder_unit.sv
// Results: a kept column's first result passes the emitter, s1, s2 and
//   output registers; the rest follow one per cycle unless stalled.
// Throughput: one channel value per cycle. The final channel of a column
//   waits only while the previous column's 1 + NUM_KEYPOINTS results are
//   still being issued into the scaling pipeline (output stalls hold it).
// Reset: control state cleared, registers back to threshold 128, pads 0,
//   inverse ratio 256; geometry and pipeline payload are not reset.
`timescale 1ns / 1ps
`default_nettype none

module pose_detection_column_decoder_unit #(
    parameter int NUM_CLASSES   = pdcd_pkg::DEF_NUM_CLASSES,
    parameter int NUM_KEYPOINTS = pdcd_pkg::DEF_NUM_KEYPOINTS
) (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    // channel_value[23:0]
    input  wire logic [pdcd_pkg::IN_TDATA_W-1:0]      s_tdata,
    input  wire logic                                 s_tvalid,
    output logic                                      s_tready,
    // class_index, best_score, point_x, point_y, box_width, box_height,
    // keypoint_number, zero padding
    output logic [pdcd_pkg::OUT_TDATA_W-1:0]          m_tdata,
    // item_kind
    output logic                                      m_tuser,
    // last_of_run
    output logic                                      m_tlast,
    output logic                                      m_tvalid,
    input  wire logic                                 m_tready,
    input  wire logic                                 cfg_we,
    input  wire logic [pdcd_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  wire logic [pdcd_pkg::CFG_DATA_W-1:0]      cfg_data
);

    localparam int GEOM_DEPTH = pdcd_pkg::BOX_CH + 2 * NUM_KEYPOINTS;

    logic [pdcd_pkg::THR_W-1:0]   threshold_reg;
    logic [pdcd_pkg::PAD_W-1:0]   pad_x_reg;
    logic [pdcd_pkg::PAD_W-1:0]   pad_y_reg;
    logic [pdcd_pkg::RATIO_W-1:0] ratio_reg;

    logic                 in_fire;
    logic                 at_last;
    logic                 busy;
    logic                 take;
    pdcd_pkg::col_done_t  done;
    pdcd_pkg::value_t     col_geom [GEOM_DEPTH];
    pdcd_pkg::issue_t     issue;
    pdcd_pkg::result_t    result;

    // a new column may close only once the previous snapshot is free
    assign s_tready = !(at_last && busy);
    assign in_fire  = s_tvalid && s_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            threshold_reg <= pdcd_pkg::THRESHOLD_RST;
            pad_x_reg     <= '0;
            pad_y_reg     <= '0;
            ratio_reg     <= pdcd_pkg::RATIO_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                pdcd_pkg::CFG_THRESHOLD: threshold_reg <= cfg_data[pdcd_pkg::THR_W-1:0];
                pdcd_pkg::CFG_PAD_X:     pad_x_reg     <= cfg_data[pdcd_pkg::PAD_W-1:0];
                pdcd_pkg::CFG_PAD_Y:     pad_y_reg     <= cfg_data[pdcd_pkg::PAD_W-1:0];
                pdcd_pkg::CFG_RATIO:     ratio_reg     <= cfg_data[pdcd_pkg::RATIO_W-1:0];
                default:                 ratio_reg     <= ratio_reg;
            endcase
        end
    end

    pdcd_tracker #(
        .NUM_CLASSES   (NUM_CLASSES),
        .NUM_KEYPOINTS (NUM_KEYPOINTS)
    ) u_tracker (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_fire         (in_fire),
        .in_value        (pdcd_pkg::value_t'(s_tdata[pdcd_pkg::VAL_W-1:0])),
        .score_threshold (threshold_reg),
        .at_last         (at_last),
        .done            (done),
        .col_geom        (col_geom)
    );

    pdcd_emitter #(
        .NUM_KEYPOINTS (NUM_KEYPOINTS)
    ) u_emitter (
        .clk      (clk),
        .rst_n    (rst_n),
        .done     (done),
        .col_geom (col_geom),
        .take     (take),
        .busy     (busy),
        .issue    (issue)
    );

    pdcd_scaler u_scaler (
        .clk         (clk),
        .rst_n       (rst_n),
        .issue_valid (busy),
        .issue       (issue),
        .pad_x       (pad_x_reg),
        .pad_y       (pad_y_reg),
        .ratio       (ratio_reg),
        .out_ready   (m_tready),
        .take        (take),
        .out_valid   (m_tvalid),
        .result      (result)
    );

    always_comb
    begin
        m_tdata = '0;
        m_tdata[pdcd_pkg::CLS_LSB   +: pdcd_pkg::CLS_OUT_W] = result.meta.cls;
        m_tdata[pdcd_pkg::SCORE_LSB +: pdcd_pkg::VAL_W]     = result.meta.score;
        m_tdata[pdcd_pkg::PX_LSB    +: pdcd_pkg::COORD_W]   = result.px;
        m_tdata[pdcd_pkg::PY_LSB    +: pdcd_pkg::COORD_W]   = result.py;
        m_tdata[pdcd_pkg::BW_LSB    +: pdcd_pkg::COORD_W]   = result.bw;
        m_tdata[pdcd_pkg::BH_LSB    +: pdcd_pkg::COORD_W]   = result.bh;
        m_tdata[pdcd_pkg::KN_LSB    +: pdcd_pkg::KN_W]      = result.meta.kn;
        m_tuser = !result.meta.is_box;
        m_tlast = result.meta.last;
    end

endmodule

`default_nettype wire

### sv/pdcd_checker.sv
// Port-level checker for the column decoder, bound to the top level.
// Depends on pdcd_pkg and the assertion macro header.
`timescale 1ns / 1ps
`default_nettype none
`include "pose_detection_column_decoder_unit_macros.svh"

module pdcd_checker (
    input wire logic                                clk,
    input wire logic                                rst_n,
    input wire logic [pdcd_pkg::OUT_TDATA_W-1:0]    m_tdata,
    input wire logic                                m_tuser,
    input wire logic                                m_tlast,
    input wire logic                                m_tvalid,
    input wire logic                                m_tready
);

    `PDCD_ASSERT_NOW(a_last_is_keypoint, m_tvalid && m_tlast, m_tuser, "run closed by a box result")
    `PDCD_ASSERT_NOW(a_box_kn_zero, m_tvalid && !m_tuser, m_tdata[pdcd_pkg::KN_LSB +: pdcd_pkg::KN_W] == '0, "box result with keypoint number")
    `PDCD_ASSERT_NOW(a_kp_size_zero, m_tvalid && m_tuser, (m_tdata[pdcd_pkg::BW_LSB +: pdcd_pkg::COORD_W] == '0) && (m_tdata[pdcd_pkg::BH_LSB +: pdcd_pkg::COORD_W] == '0), "keypoint result with box size")
    `PDCD_ASSERT_NEXT(a_stall_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tlast), "result changed while stalled")

endmodule

bind pose_detection_column_decoder_unit pdcd_checker u_pdcd_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready)
);

`default_nettype wire
